@@ hdl/rbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared constants and types of the ROM bank mapper: sizes, decoded I/O
// addresses, register indexes, reset values, result action codes and op codes.
// ----------------------------------------------------------------------------
package rbm_pkg;

	// sizes (powers of two)
	localparam int RAM_DEPTH    = 256;
	localparam int WINDOW_BYTES = 16384;
	localparam int BANK_COUNT   = 64;

	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int OFF_W  = $clog2(WINDOW_BYTES);
	localparam int BANK_W = $clog2(BANK_COUNT);

	// field widths
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int ROMBNK_W = 6;
	localparam int ROMOFF_W = 14;

	// decoded I/O1 register addresses
	localparam logic [ADDR_W-1:0] BANK_REG_ADDR = 16'hDE00;
	localparam logic [ADDR_W-1:0] MODE_REG_ADDR = 16'hDE02;

	// configuration register reset values
	localparam logic [ADDR_W-1:0] ROM_LOW_BASE_RST  = 16'h8000;
	localparam logic [ADDR_W-1:0] ROM_HIGH_BASE_RST = 16'hA000;
	localparam logic              INIT_EXROM_RST    = 1'b1;
	localparam logic              INIT_GAME_RST     = 1'b0;

	typedef enum logic [1:0] {
		CFG_ROM_LOW_BASE  = 2'd0,
		CFG_ROM_HIGH_BASE = 2'd1,
		CFG_INIT_EXROM    = 2'd2,
		CFG_INIT_GAME     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_LOW_ROM  = 2'd1,
		ACT_HIGH_ROM = 2'd2,
		ACT_RAM_READ = 2'd3
	} action_t;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

endpackage

@@ hdl/rbm_ram.sv @@
// ----------------------------------------------------------------------------
// rbm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/rom_bank_mapper_with_ram_and_mode_top.sv @@
// pipeline: two register stages (decode register, output register) lie
//   between an accepted transaction and its result on the output
// throughput: one transaction per clock; the input stalls only while both
//   stages hold a result and m_tready is low
// reset: arst_n clears bank, mode and handshake state and loads the config
//   registers; RAM contents are not reset, a per-entry valid flag reads them as zero
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_ram_and_mode_top
// Cartridge-port mapper: decodes one host bus access per transaction into a
// ROM fetch (bank and window offset) or a scratch RAM read, and handles the
// bank, mode and RAM writes.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_ram_and_mode_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// host bus access in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // address[15:0], write_data[23:16], low_rom_select[24],
	                              // high_rom_select[25], io_one_select[26],
	                              // io_two_select[27], zero[31:28]
	input  logic        s_tuser,  // op[0]
	// mapper result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // rom_bank[5:0], rom_offset[19:6], read_data[27:20],
	                              // exrom_level[28], game_level[29], zero[31:30]
	output logic [1:0]  m_tuser   // action[1:0]
);
	import rbm_pkg::*;

	// configuration registers
	logic [ADDR_W-1:0] rom_low_base_q;
	logic [ADDR_W-1:0] rom_high_base_q;
	logic              init_exrom_q;
	logic              init_game_q;

	// mapper state
	logic [BANK_W-1:0] bank_q;
	logic              exrom_line_q;
	logic              game_line_q;
	logic              mode_written_q;
	logic [RAM_DEPTH-1:0] ram_vld_q;

	// stage 1: decoded access, RAM read in flight
	logic                v1_q;
	action_t             action_s1;
	logic [ROMBNK_W-1:0] bank_s1;
	logic [ROMOFF_W-1:0] offset_s1;
	logic                exrom_s1;
	logic                game_s1;
	logic                ram_vld_s1;

	// stage 2: output register
	logic                v2_q;
	action_t             action_s2;
	logic [ROMBNK_W-1:0] bank_s2;
	logic [ROMOFF_W-1:0] offset_s2;
	logic [DATA_W-1:0]   rdata_s2;
	logic                exrom_s2;
	logic                game_s2;

	// unpacked input fields
	op_t               in_op;
	logic [ADDR_W-1:0] in_addr;
	logic [DATA_W-1:0] in_wdata;
	logic              in_low_sel;
	logic              in_high_sel;
	logic              in_io1_sel;
	logic              in_io2_sel;

	logic              accept;
	logic              advance;
	logic              is_read;
	logic              bank_wr;
	logic              mode_wr;
	logic              ram_wr;
	logic [RAM_AW-1:0] ram_idx;
	logic [ADDR_W-1:0] win_diff;
	logic              new_exrom;
	logic              new_game;
	logic              exrom_lvl;
	logic              game_lvl;
	action_t           action_d;
	logic [DATA_W-1:0] ram_dout;

	assign in_op       = op_t'(s_tuser);
	assign in_addr     = s_tdata[15:0];
	assign in_wdata    = s_tdata[23:16];
	assign in_low_sel  = s_tdata[24];
	assign in_high_sel = s_tdata[25];
	assign in_io1_sel  = s_tdata[26];
	assign in_io2_sel  = s_tdata[27];

	// handshake: stage 1 drains into the output register whenever that is
	// free or being emptied, so a new access is taken while a result waits
	assign advance  = !v2_q || m_tready;
	assign s_tready = !v1_q || advance;
	assign accept   = s_tvalid && s_tready;

	// access decode
	assign is_read = (in_op == OP_READ);
	assign bank_wr = !is_read && in_io1_sel && (in_addr == BANK_REG_ADDR);
	assign mode_wr = !is_read && in_io1_sel && (in_addr == MODE_REG_ADDR);
	assign ram_wr  = !is_read && !bank_wr && !mode_wr && in_io2_sel;
	assign ram_idx = in_addr[RAM_AW-1:0];

	always_comb begin
		if (is_read && in_low_sel) begin
			action_d = ACT_LOW_ROM;
		end else if (is_read && in_high_sel) begin
			action_d = ACT_HIGH_ROM;
		end else if (is_read && in_io2_sel) begin
			action_d = ACT_RAM_READ;
		end else begin
			action_d = ACT_NONE;
		end
	end

	// offset inside the selected window, wrapping at 16 bits
	assign win_diff = in_addr - ((action_d == ACT_HIGH_ROM) ? rom_high_base_q : rom_low_base_q);

	// mode byte: exrom low when bit1 set, game high when bit2 set and bit0 clear
	assign new_exrom = !in_wdata[1];
	assign new_game  = in_wdata[2] && !in_wdata[0];

	// line levels after this access; the init registers rule until a mode write
	assign exrom_lvl = mode_wr ? new_exrom : (mode_written_q ? exrom_line_q : init_exrom_q);
	assign game_lvl  = mode_wr ? new_game  : (mode_written_q ? game_line_q  : init_game_q);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_low_base_q  <= ROM_LOW_BASE_RST;
			rom_high_base_q <= ROM_HIGH_BASE_RST;
			init_exrom_q    <= INIT_EXROM_RST;
			init_game_q     <= INIT_GAME_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROM_LOW_BASE:  rom_low_base_q  <= cfg_data;
				CFG_ROM_HIGH_BASE: rom_high_base_q <= cfg_data;
				CFG_INIT_EXROM:    init_exrom_q    <= cfg_data[0];
				CFG_INIT_GAME:     init_game_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bank and mode registers, RAM entry valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q         <= '0;
			exrom_line_q   <= 1'b0;
			game_line_q    <= 1'b0;
			mode_written_q <= 1'b0;
			ram_vld_q      <= '0;
		end else if (accept) begin
			if (bank_wr) begin
				bank_q <= in_wdata[BANK_W-1:0];
			end
			if (mode_wr) begin
				exrom_line_q   <= new_exrom;
				game_line_q    <= new_game;
				mode_written_q <= 1'b1;
			end
			if (ram_wr) begin
				ram_vld_q[ram_idx] <= 1'b1;
			end
		end
	end

	// scratch RAM: write and read both issued at accept, read data lines up
	// with stage 1
	rbm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_scratch_ram (
		.clk   (clk),
		.we    (accept && ram_wr),
		.waddr (ram_idx),
		.wdata (in_wdata),
		.re    (accept),
		.raddr (ram_idx),
		.rdata (ram_dout)
	);

	// stage 1 and stage 2 valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (advance) begin
				v1_q <= 1'b0;
			end
			if (advance) begin
				v2_q <= v1_q;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action_d;
			bank_s1    <= (action_d == ACT_LOW_ROM || action_d == ACT_HIGH_ROM)
				? ROMBNK_W'(bank_q) : '0;
			offset_s1  <= (action_d == ACT_LOW_ROM || action_d == ACT_HIGH_ROM)
				? ROMOFF_W'(win_diff[OFF_W-1:0]) : '0;
			exrom_s1   <= exrom_lvl;
			game_s1    <= game_lvl;
			ram_vld_s1 <= ram_vld_q[ram_idx];
		end
	end

	// stage 2 payload; an unwritten RAM entry reads as zero
	always_ff @(posedge clk) begin
		if (advance && v1_q) begin
			action_s2 <= action_s1;
			bank_s2   <= bank_s1;
			offset_s2 <= offset_s1;
			rdata_s2  <= (action_s1 == ACT_RAM_READ && ram_vld_s1) ? ram_dout : '0;
			exrom_s2  <= exrom_s1;
			game_s2   <= game_s1;
		end
	end

	assign m_tvalid = v2_q;
	assign m_tuser  = action_s2;
	assign m_tdata  = {2'b00, game_s2, exrom_s2, rdata_s2, offset_s2, bank_s2};

`ifndef SYNTHESIS
	// input stalls only when both stages hold a result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1_q && v2_q))
		else $error("input stalled with a free stage");

	// a bank write lands in the bank register
	a_bank_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bank_wr) |=> (bank_q == $past(in_wdata[BANK_W-1:0])))
		else $error("bank register not loaded");

	// read data only on a RAM read
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && action_s2 != ACT_RAM_READ) |-> (rdata_s2 == '0))
		else $error("read data set outside a RAM read");

	// ROM fields only on a ROM fetch
	a_rom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && action_s2 != ACT_LOW_ROM && action_s2 != ACT_HIGH_ROM)
		|-> (bank_s2 == '0 && offset_s2 == '0))
		else $error("ROM fields set outside a ROM fetch");
`endif

endmodule

@@ tb/sv/rom_bank_mapper_with_ram_and_mode_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_ram_and_mode_checker
// Watches the config port and both stream channels of the mapper. It keeps
// its own copy of bank, mode lines, window bases and scratch RAM, predicts
// one result per accepted host access and compares it field by field.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_ram_and_mode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatch_count,
	output int          pending_count,
	output int          results_checked
);
	import rbm_pkg::*;

	typedef struct packed {
		op_t                 op;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   write_data;
		logic                low_sel;
		logic                high_sel;
		logic                io1_sel;
		logic                io2_sel;
	} bus_access_t;

	typedef struct packed {
		action_t             action;
		logic [ROMBNK_W-1:0] bank;
		logic [ROMOFF_W-1:0] offset;
		logic [DATA_W-1:0]   read_data;
		logic                exrom;
		logic                game;
	} map_result_t;

	// mapper copy
	logic [ADDR_W-1:0]   low_base_q;
	logic [ADDR_W-1:0]   high_base_q;
	logic                init_exrom_q;
	logic                init_game_q;
	logic [ROMBNK_W-1:0] bank_q;
	logic                mode_set_q;
	logic                exrom_q;
	logic                game_q;
	logic [DATA_W-1:0]   ram_q [RAM_DEPTH];

	map_result_t pending_results [$];
	int          errors_found;
	int          checked;

	function automatic logic [ROMOFF_W-1:0] window_offset(input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] diff;
		diff = addr - base;
		return diff[ROMOFF_W-1:0];
	endfunction

	// one host access against the mapper copy, updates it on writes
	function automatic map_result_t decode_access(input bus_access_t a);
		map_result_t         r;
		logic [RAM_AW-1:0]   slot;
		r.action    = ACT_NONE;
		r.bank      = '0;
		r.offset    = '0;
		r.read_data = '0;
		slot        = a.address[RAM_AW-1:0];
		if (a.op == OP_READ) begin
			if (a.low_sel) begin
				r.action = ACT_LOW_ROM;
				r.bank   = bank_q;
				r.offset = window_offset(a.address, low_base_q);
			end else if (a.high_sel) begin
				r.action = ACT_HIGH_ROM;
				r.bank   = bank_q;
				r.offset = window_offset(a.address, high_base_q);
			end else if (a.io2_sel) begin
				r.action    = ACT_RAM_READ;
				r.read_data = ram_q[slot];
			end
		end else begin
			if (a.io1_sel && a.address == BANK_REG_ADDR) begin
				bank_q = a.write_data[BANK_W-1:0];
			end else if (a.io1_sel && a.address == MODE_REG_ADDR) begin
				// data bit 1 pulls exrom low, game needs bit 2 with bit 0 clear
				exrom_q    = ~a.write_data[1];
				game_q     = a.write_data[2] & ~a.write_data[0];
				mode_set_q = 1'b1;
			end else if (a.io2_sel) begin
				ram_q[slot] = a.write_data;
			end
		end
		r.exrom = mode_set_q ? exrom_q : init_exrom_q;
		r.game  = mode_set_q ? game_q : init_game_q;
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic void check_result(input map_result_t want);
		int bad;
		bad = 0;
		bad += field_differs("action", 16'(want.action), 16'(m_tuser));
		bad += field_differs("rom_bank", 16'(want.bank), 16'(m_tdata[5:0]));
		bad += field_differs("rom_offset", 16'(want.offset), 16'(m_tdata[19:6]));
		bad += field_differs("read_data", 16'(want.read_data), 16'(m_tdata[27:20]));
		bad += field_differs("exrom_level", 16'(want.exrom), 16'(m_tdata[28]));
		bad += field_differs("game_level", 16'(want.game), 16'(m_tdata[29]));
		if (bad != 0)
			errors_found++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_access_t acc;
		if (!arst_n) begin
			low_base_q   = ROM_LOW_BASE_RST;
			high_base_q  = ROM_HIGH_BASE_RST;
			init_exrom_q = INIT_EXROM_RST;
			init_game_q  = INIT_GAME_RST;
			bank_q       = '0;
			mode_set_q   = 1'b0;
			exrom_q      = 1'b1;
			game_q       = 1'b0;
			for (int i = 0; i < RAM_DEPTH; i++)
				ram_q[i] = '0;
			pending_results.delete();
			errors_found = 0;
			checked      = 0;
			mismatch_count  <= 0;
			pending_count   <= 0;
			results_checked <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual action 0x%0h data 0x%0h",
						$time, m_tuser, m_tdata);
					errors_found++;
				end else begin
					check_result(pending_results.pop_front());
					checked++;
				end
			end
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ROM_LOW_BASE:  low_base_q   = cfg_data;
					CFG_ROM_HIGH_BASE: high_base_q  = cfg_data;
					CFG_INIT_EXROM:    init_exrom_q = cfg_data[0];
					CFG_INIT_GAME:     init_game_q  = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				acc.op         = op_t'(s_tuser);
				acc.address    = s_tdata[15:0];
				acc.write_data = s_tdata[23:16];
				acc.low_sel    = s_tdata[24];
				acc.high_sel   = s_tdata[25];
				acc.io1_sel    = s_tdata[26];
				acc.io2_sel    = s_tdata[27];
				pending_results.push_back(decode_access(acc));
			end
			mismatch_count  <= errors_found;
			pending_count   <= pending_results.size();
			results_checked <= checked;
		end
	end

endmodule

@@ tb/sv/rom_bank_mapper_with_ram_and_mode_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_ram_and_mode_top_tb
// Drives host bus accesses into the mapper in bursts, stalls the result side
// on its own pattern, steps through several window base and line settings,
// and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_ram_and_mode_top_tb;
	import rbm_pkg::*;

	// strobe bits as they sit in tdata[27:24]
	localparam logic [3:0] SEL_NONE = 4'b0000;
	localparam logic [3:0] SEL_LOW  = 4'b0001;
	localparam logic [3:0] SEL_HIGH = 4'b0010;
	localparam logic [3:0] SEL_IO1  = 4'b0100;
	localparam logic [3:0] SEL_IO2  = 4'b1000;

	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 88;
	localparam int LATENCY_TAIL     = 6;    // two register stages plus margin
	localparam int IDLE_LIMIT       = 2000; // cycles with no transaction at all

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	int mismatch_count;
	int pending_count;
	int results_checked;

	// stimulus bookkeeping
	int                burst_left = 0;
	int                accesses_sent = 0;
	int                directed_count = 0;
	int                settings_used = 0;
	logic [ADDR_W-1:0] cur_low_base;
	logic [ADDR_W-1:0] cur_high_base;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rom_bank_mapper_with_ram_and_mode_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rom_bank_mapper_with_ram_and_mode_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.results_checked(results_checked)
	);

	// one host access; the sender runs in bursts and may idle before a new one
	task automatic send_access(input op_t op, input logic [15:0] addr,
			input logic [7:0] data, input logic [3:0] sel);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			// some bursts start back to back, so not every burst has a gap
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0000, sel, data, addr};
		// transaction takes place at the edge where tready was high
		do @(posedge clk); while (!s_tready);
		accesses_sent++;
	endtask

	// stop sending and hold off until every expected result is back
	task automatic wait_until_idle();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		// first let the checker count take in the last transaction
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (LATENCY_TAIL) @(posedge clk);
	endtask

	// all four config registers, one per clock, only while the block is idle
	task automatic write_setting(input logic [15:0] low_base, input logic [15:0] high_base,
			input logic exrom, input logic game);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ROM_LOW_BASE;
		cfg_data  <= low_base;
		@(posedge clk);
		cfg_index <= CFG_ROM_HIGH_BASE;
		cfg_data  <= high_base;
		@(posedge clk);
		cfg_index <= CFG_INIT_EXROM;
		cfg_data  <= {15'b0, exrom};
		@(posedge clk);
		cfg_index <= CFG_INIT_GAME;
		cfg_data  <= {15'b0, game};
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		cur_low_base  = low_base;
		cur_high_base = high_base;
		settings_used++;
	endtask

	// low RAM byte, half the time from a small hot set so reads hit written entries
	function automatic logic [7:0] ram_slot();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 15));
		return 8'($urandom);
	endfunction

	// mostly well-formed accesses with random content, the rest pure noise
	task automatic send_random_access();
		logic [15:0] addr;
		logic [7:0]  data;
		logic [3:0]  sel;
		int          pick;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom);
		data = 8'($urandom);
		sel  = 4'($urandom);
		if (pick < 35) begin
			// rom fetch, often aimed inside the current window
			if ($urandom_range(0, 1) == 0) begin
				sel = sel | SEL_LOW;
				if (pick < 20)
					addr = cur_low_base + 16'($urandom_range(0, WINDOW_BYTES - 1));
			end else begin
				sel = (sel & ~SEL_LOW) | SEL_HIGH;
				if (pick < 20)
					addr = cur_high_base + 16'($urandom_range(0, WINDOW_BYTES - 1));
			end
			send_access(OP_READ, addr, data, sel);
		end else if (pick < 50) begin
			// scratch RAM read, io1 may ride along
			sel = (sel & SEL_IO1) | SEL_IO2;
			send_access(OP_READ, {addr[15:8], ram_slot()}, data, sel);
		end else if (pick < 65) begin
			// scratch RAM write, rom strobes do not matter on a write
			sel = (sel & (SEL_LOW | SEL_HIGH)) | SEL_IO2;
			send_access(OP_WRITE, {addr[15:8], ram_slot()}, data, sel);
		end else if (pick < 75) begin
			send_access(OP_WRITE, BANK_REG_ADDR, data, sel | SEL_IO1);
		end else if (pick < 82) begin
			send_access(OP_WRITE, MODE_REG_ADDR, data, sel | SEL_IO1);
		end else begin
			send_access(op_t'($urandom_range(0, 1)), addr, data, sel);
		end
	endtask

	// result side: stretches of always-ready, coin-flip, mostly-stalled and
	// a repeating on-off rhythm
	initial begin : sink_pattern
		int style;
		int stretch;
		int tick;
		tick = 0;
		m_tready <= 1'b0;
		forever begin
			style   = $urandom_range(0, 3);
			stretch = $urandom_range(8, 80);
			repeat (stretch) begin
				@(posedge clk);
				tick++;
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 1) == 1);
					2:       m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= ((tick % 5) < 3);
				endcase
			end
		end
	end

	// watchdog: too long without any transaction ends the run
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, pending_count);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		cfg_wr_en     <= 1'b0;
		cfg_index     <= CFG_ROM_LOW_BASE;
		cfg_data      <= '0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		s_tuser       <= OP_READ;
		arst_n        <= 1'b0;
		cur_low_base  = ROM_LOW_BASE_RST;
		cur_high_base = ROM_HIGH_BASE_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window edges, wrap below base, strobe priority, idle strobes
		send_access(OP_READ, 16'h8000, 8'h00, SEL_LOW);
		send_access(OP_READ, 16'hBFFF, 8'hFF, SEL_LOW);
		send_access(OP_READ, 16'hA000, 8'h00, SEL_HIGH);
		send_access(OP_READ, 16'h9FFF, 8'h00, SEL_HIGH);
		send_access(OP_READ, 16'h8123, 8'h00, SEL_LOW | SEL_HIGH | SEL_IO1 | SEL_IO2);
		send_access(OP_READ, 16'hDE00, 8'h00, SEL_IO1);
		send_access(OP_READ, 16'hFFFF, 8'h00, SEL_NONE);
		// unwritten RAM entry reads as zero
		send_access(OP_READ, 16'hDE42, 8'h00, SEL_IO2);

		// initial line levels flipped before any mode write, so they show at once
		wait_until_idle();
		write_setting(16'h0000, 16'hFFFF, 1'b0, 1'b1);
		send_access(OP_READ, 16'h0000, 8'h00, SEL_LOW);
		send_access(OP_READ, 16'hFFFE, 8'h00, SEL_HIGH);
		// bank: top value, then cleared by a write whose upper bits are dropped
		send_access(OP_WRITE, BANK_REG_ADDR, 8'hFF, SEL_IO1);
		send_access(OP_READ, 16'h1234, 8'h00, SEL_HIGH | SEL_IO2);
		send_access(OP_WRITE, BANK_REG_ADDR, 8'h40, SEL_IO1 | SEL_IO2);
		// RAM writes: last entry, io2 alone at the bank address, io1 off-register
		send_access(OP_WRITE, 16'hDFFF, 8'hFF, SEL_IO2);
		send_access(OP_WRITE, 16'hDE00, 8'hA5, SEL_IO2);
		send_access(OP_WRITE, 16'hDE01, 8'h5A, SEL_IO1 | SEL_IO2);
		// write with only rom strobes changes nothing
		send_access(OP_WRITE, MODE_REG_ADDR, 8'h00, SEL_LOW | SEL_HIGH);
		send_access(OP_READ, 16'h00FF, 8'h00, SEL_IO2);
		send_access(OP_READ, 16'h0000, 8'h00, SEL_IO2);
		send_access(OP_READ, 16'h1201, 8'h00, SEL_IO2);
		// mode decode: game needs bit 2 without bit 0, bit 1 drops exrom, bit 7 is free
		send_access(OP_WRITE, MODE_REG_ADDR, 8'h04, SEL_IO1);
		send_access(OP_WRITE, MODE_REG_ADDR, 8'h05, SEL_IO1);
		send_access(OP_WRITE, MODE_REG_ADDR, 8'h02, SEL_IO1);
		send_access(OP_WRITE, MODE_REG_ADDR, 8'h86, SEL_IO1);
		// mode write with io2 too must not touch RAM entry two
		send_access(OP_WRITE, MODE_REG_ADDR, 8'hFF, SEL_IO1 | SEL_IO2);
		send_access(OP_READ, 16'h0002, 8'h00, SEL_IO2);
		directed_count = accesses_sent;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// sender holds off until every result is back before the setting changes
			wait_until_idle();
			case (phase)
				0: write_setting(ROM_LOW_BASE_RST, ROM_HIGH_BASE_RST, INIT_EXROM_RST,
					INIT_GAME_RST);
				1: write_setting(16'hFFFF, 16'h0000, 1'b1, 1'b1);
				2: write_setting(16'h4000, 16'hC000, 1'b0, 1'b0);
				3: write_setting(16'h0001, 16'h7FFF, 1'b1, 1'b0);
				default: write_setting(16'($urandom), 16'($urandom), 1'($urandom),
					1'($urandom));
			endcase
			repeat (ITEMS_PER_PHASE)
				send_random_access();
		end

		wait_until_idle();
		repeat (LATENCY_TAIL) @(posedge clk);

		$display("covered %0d host accesses (%0d directed) under %0d window and line settings",
			accesses_sent, directed_count, settings_used + 1);
		$display("checked %0d results, %0d mismatching, %0d left outstanding",
			results_checked, mismatch_count, pending_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
